>>> rtl/core/bps_pkg.sv
// Package for the bimodal branch predictor scorer.
// Item and result types, table entry layout, decode constants and small helpers.
// No dependencies.
`default_nettype none

package bps_pkg;

	// Predictor table geometry (power of two, indexed by pc word address)
	localparam int TABLE_ENTRIES = 1024;
	localparam int IDX_W         = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

	// RISC-V conditional branch decode
	localparam logic [6:0] OPC_BRANCH = 7'b1100011;
	localparam logic [2:0] F3_RSV_A   = 3'b010;
	localparam logic [2:0] F3_RSV_B   = 3'b011;

	// 2-bit counter codes
	localparam logic [1:0] CTR_STRONG_NT = 2'b00;
	localparam logic [1:0] CTR_WEAK_NT   = 2'b01;
	localparam logic [1:0] CTR_WEAK_T    = 2'b10;
	localparam logic [1:0] CTR_STRONG_T  = 2'b11;

	localparam logic [31:0] TALLY_MAX = 32'hFFFF_FFFF;

	typedef logic [IDX_W-1:0] idx_t;

	typedef struct packed {
		logic [31:0] branch_pc;
		logic [31:0] instruction_word;
		logic [31:0] following_pc;
	} in_item_t;

	typedef struct packed {
		logic        is_branch;
		logic [31:0] branch_target;
		logic        went_taken;
		logic        one_bit_right;
		logic        two_bit_right;
		logic [31:0] branches_seen;
		logic [31:0] always_taken_hits;
		logic [31:0] always_not_taken_hits;
		logic [31:0] one_bit_hits;
		logic [31:0] two_bit_hits;
	} out_item_t;

	// One predictor table row
	typedef struct packed {
		logic        valid;
		logic [31:0] tag;
		logic        last;
		logic [1:0]  ctr;
	} entry_t;

	// Decoded view of one item
	typedef struct packed {
		logic        is_branch;
		logic [31:0] pc;
		logic [31:0] target;
		logic        taken;
	} dec_t;

	typedef struct packed {
		logic [31:0] branches;
		logic [31:0] taken;
		logic [31:0] not_taken;
		logic [31:0] one_bit;
		logic [31:0] two_bit;
	} tally_t;

	// Direct-mapped index: word address modulo table size
	function automatic idx_t tbl_idx(input logic [31:0] pc);
		logic [29:0] word_addr;
		word_addr = pc[31:2];
		return idx_t'(word_addr % TABLE_ENTRIES);
	endfunction

	// Saturating increment when enabled
	function automatic logic [31:0] sat_inc(input logic [31:0] v, input logic en);
		return (en && (v != TALLY_MAX)) ? v + 32'd1 : v;
	endfunction

endpackage

`default_nettype wire

>>> rtl/core/bps_decode.sv
// Branch decode: recognizes conditional branches, forms the target, resolves taken.
// Depends on bps_pkg.
`default_nettype none

module bps_decode (
	input  bps_pkg::in_item_t item,
	output bps_pkg::dec_t     dec
);
	import bps_pkg::*;

	logic [2:0]  funct3;
	logic        br;
	logic [31:0] imm;
	logic [31:0] target;

	// Opcode and funct3 check
	assign funct3 = item.instruction_word[14:12];
	assign br     = (item.instruction_word[6:0] == OPC_BRANCH) &&
	                (funct3 != F3_RSV_A) && (funct3 != F3_RSV_B);

	// B-type immediate, sign extended
	assign imm = {{19{item.instruction_word[31]}}, item.instruction_word[31],
	              item.instruction_word[7], item.instruction_word[30:25],
	              item.instruction_word[11:8], 1'b0};

	assign target = item.branch_pc + imm;

	always_comb begin
		dec.is_branch = br;
		dec.pc        = item.branch_pc;
		dec.target    = br ? target : 32'd0;
		dec.taken     = br && (item.following_pc == target);
	end

endmodule

`default_nettype wire

>>> rtl/core/bps_table.sv
// Predictor table: single-port-write memory with registered read, a bypass of the
// latest write, and a clearing pass after reset. Depends on bps_pkg.
`default_nettype none

module bps_table (
	input  wire             clk,
	input  wire             arst_n,
	input  wire             rd_en,
	input  bps_pkg::idx_t   rd_idx,
	output bps_pkg::entry_t rd_entry,
	input  wire             wr_en,
	input  bps_pkg::idx_t   wr_idx,
	input  bps_pkg::entry_t wr_entry,
	output logic            busy
);
	import bps_pkg::*;

	entry_t mem [TABLE_ENTRIES];
	entry_t rd_data_q;
	idx_t   rd_idx_q;

	logic   clr_busy_q;
	idx_t   clr_idx_q;

	logic   byp_valid_q;
	idx_t   byp_idx_q;
	entry_t byp_data_q;

	logic   m_wr;
	idx_t   m_idx;
	entry_t m_data;

	assign busy = clr_busy_q;

	// Clearing pass owns the write port after reset
	always_comb begin
		m_wr   = clr_busy_q || wr_en;
		m_idx  = clr_busy_q ? clr_idx_q : wr_idx;
		m_data = clr_busy_q ? entry_t'('0) : wr_entry;
	end

	always_ff @(posedge clk) begin
		if (m_wr) begin
			mem[m_idx] <= m_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_idx];
			rd_idx_q  <= rd_idx;
		end
	end

	// Clear sweep, one row per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_idx_q  <= '0;
		end else if (clr_busy_q) begin
			if (clr_idx_q == idx_t'(TABLE_ENTRIES - 1)) begin
				clr_busy_q <= 1'b0;
			end
			clr_idx_q <= clr_idx_q + idx_t'(1);
		end
	end

	// Latest write, covers a read issued on the same edge
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byp_valid_q <= 1'b0;
		end else if (clr_busy_q) begin
			byp_valid_q <= 1'b0;
		end else if (wr_en) begin
			byp_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en && !clr_busy_q) begin
			byp_idx_q  <= wr_idx;
			byp_data_q <= wr_entry;
		end
	end

	assign rd_entry = (byp_valid_q && (byp_idx_q == rd_idx_q)) ? byp_data_q : rd_data_q;

`ifndef ASSERT_OFF
	a_no_read_clear: assert property (@(posedge clk) disable iff (!arst_n)
		clr_busy_q |-> !rd_en)
		else $error("table read during clearing pass");
	a_no_write_clear: assert property (@(posedge clk) disable iff (!arst_n)
		clr_busy_q |-> !wr_en)
		else $error("table update during clearing pass");
`endif

endmodule

`default_nettype wire

>>> rtl/core/bps_score.sv
// Scoring: checks both predictors against the outcome, builds the updated table row
// and keeps the saturating totals. Depends on bps_pkg.
`default_nettype none

module bps_score (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               fire,
	input  bps_pkg::dec_t     dec,
	input  bps_pkg::entry_t   entry,
	output bps_pkg::entry_t   new_entry,
	output bps_pkg::out_item_t res
);
	import bps_pkg::*;

	tally_t tally_q;
	tally_t tally_nx;
	logic   hit;
	logic   cur_last;
	logic   [1:0] cur_ctr;
	logic   [1:0] nxt_ctr;
	logic   one_ok;
	logic   two_ok;

	// A missing or foreign row starts at not taken, strong not taken
	assign hit      = entry.valid && (entry.tag == dec.pc);
	assign cur_last = hit ? entry.last : 1'b0;
	assign cur_ctr  = hit ? entry.ctr : CTR_STRONG_NT;

	assign one_ok = dec.is_branch && (cur_last == dec.taken);
	assign two_ok = dec.is_branch && (cur_ctr[1] == dec.taken);

	// Counter step toward the outcome
	always_comb begin
		nxt_ctr = cur_ctr;
		case (cur_ctr)
			CTR_STRONG_NT: nxt_ctr = dec.taken ? CTR_WEAK_NT  : CTR_STRONG_NT;
			CTR_WEAK_NT:   nxt_ctr = dec.taken ? CTR_WEAK_T   : CTR_STRONG_NT;
			CTR_WEAK_T:    nxt_ctr = dec.taken ? CTR_STRONG_T : CTR_WEAK_NT;
			CTR_STRONG_T:  nxt_ctr = dec.taken ? CTR_STRONG_T : CTR_WEAK_T;
			default:       nxt_ctr = CTR_STRONG_NT;
		endcase
	end

	always_comb begin
		new_entry.valid = 1'b1;
		new_entry.tag   = dec.pc;
		new_entry.last  = dec.taken;
		new_entry.ctr   = nxt_ctr;
	end

	// Totals after this item
	always_comb begin
		tally_nx.branches  = sat_inc(tally_q.branches, dec.is_branch);
		tally_nx.taken     = sat_inc(tally_q.taken, dec.is_branch && dec.taken);
		tally_nx.not_taken = sat_inc(tally_q.not_taken, dec.is_branch && !dec.taken);
		tally_nx.one_bit   = sat_inc(tally_q.one_bit, one_ok);
		tally_nx.two_bit   = sat_inc(tally_q.two_bit, two_ok);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tally_q <= '0;
		end else if (fire) begin
			tally_q <= tally_nx;
		end
	end

	always_comb begin
		res.is_branch             = dec.is_branch;
		res.branch_target         = dec.target;
		res.went_taken            = dec.taken;
		res.one_bit_right         = one_ok;
		res.two_bit_right         = two_ok;
		res.branches_seen         = tally_nx.branches;
		res.always_taken_hits     = tally_nx.taken;
		res.always_not_taken_hits = tally_nx.not_taken;
		res.one_bit_hits          = tally_nx.one_bit;
		res.two_bit_hits          = tally_nx.two_bit;
	end

`ifndef ASSERT_OFF
	a_branches_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		tally_q.branches >= $past(tally_q.branches))
		else $error("branch total went down");
	a_hits_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		(tally_q.one_bit <= tally_q.branches) && (tally_q.two_bit <= tally_q.branches))
		else $error("hit total exceeds branch total");
	a_non_branch_keeps: assert property (@(posedge clk) disable iff (!arst_n)
		fire && !dec.is_branch |=> $stable(tally_q))
		else $error("totals changed on a non-branch item");
`endif

endmodule

`default_nettype wire

>>> rtl/core/riscv_branch_predictor_scorer.sv
// Bimodal branch predictor scorer, top level.
// Path: an input stage with the table read, then the scoring logic into the result register.
// Throughput: 1 item per cycle; a held result stalls the input.
// Reset: tallies and control clear at once; then a pass clears the table memory one
// row a cycle, with item_ready low until it ends.
`default_nettype none

module riscv_branch_predictor_scorer (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  item_valid,
	output logic                 item_ready,
	input  bps_pkg::in_item_t    item,
	output logic                 result_valid,
	input  wire                  result_ready,
	output bps_pkg::out_item_t   result
);
	import bps_pkg::*;

	in_item_t  item_s1;
	logic      valid_s1;
	logic      out_valid_q;
	out_item_t out_q;

	logic      accept;
	logic      fire_s1;
	logic      tbl_busy;
	dec_t      dec;
	entry_t    rd_entry;
	entry_t    new_entry;
	out_item_t res;

	// Handshake: stage 1 moves on when the result register is free or drained
	assign fire_s1    = valid_s1 && (!out_valid_q || result_ready);
	assign item_ready = !tbl_busy && (!valid_s1 || fire_s1);
	assign accept     = item_valid && item_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (fire_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= item;
		end
	end

	bps_decode u_decode (
		.item (item_s1),
		.dec  (dec)
	);

	bps_table u_table (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_en    (accept),
		.rd_idx   (tbl_idx(item.branch_pc)),
		.rd_entry (rd_entry),
		.wr_en    (fire_s1 && dec.is_branch),
		.wr_idx   (tbl_idx(item_s1.branch_pc)),
		.wr_entry (new_entry),
		.busy     (tbl_busy)
	);

	bps_score u_score (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (fire_s1),
		.dec       (dec),
		.entry     (rd_entry),
		.new_entry (new_entry),
		.res       (res)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire_s1) begin
			out_valid_q <= 1'b1;
		end else if (result_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1) begin
			out_q <= res;
		end
	end

	assign result_valid = out_valid_q;
	assign result       = out_q;

`ifndef ASSERT_OFF
	a_fire_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		fire_s1 |=> result_valid)
		else $error("scored item did not reach the result register");
`endif

endmodule

`default_nettype wire

>>> bench/riscv_branch_predictor_scorer_tb.sv
// Testbench for the bimodal branch predictor scorer: random and directed retired instructions.
// A scoreboard class keeps its own predictor table and tallies and checks every result item.
// Depends on bps_pkg and riscv_branch_predictor_scorer.
module riscv_branch_predictor_scorer_tb;
	import bps_pkg::*;

	localparam int WATCHDOG_LIMIT = 8000;
	localparam int RX_HOLD_CYCLES = 400;
	localparam int N_SITES        = 48;

	// Conditional branch funct3 codes
	localparam logic [2:0] F3_BEQ  = 3'b000;
	localparam logic [2:0] F3_BNE  = 3'b001;
	localparam logic [2:0] F3_BLT  = 3'b100;
	localparam logic [2:0] F3_BGE  = 3'b101;
	localparam logic [2:0] F3_BLTU = 3'b110;
	localparam logic [2:0] F3_BGEU = 3'b111;

	// Scoreboard: shadow predictor table, tallies and the queue of predicted results
	class branch_score_board;
		bit          row_valid [TABLE_ENTRIES];
		logic [31:0] row_tag   [TABLE_ENTRIES];
		bit          row_last  [TABLE_ENTRIES];
		logic [1:0]  row_ctr   [TABLE_ENTRIES];
		tally_t      totals;
		out_item_t   expected_scores[$];
		int          mismatches;
		int          results_seen;

		function new();
			foreach (row_valid[i]) row_valid[i] = 0;
			totals       = '0;
			mismatches   = 0;
			results_seen = 0;
		endfunction

		function logic [31:0] bump(input logic [31:0] v, input bit en);
			if (en && v != TALLY_MAX)
				return v + 32'd1;
			return v;
		endfunction

		// Score one accepted item and queue the result it should produce
		function void score_retired(input in_item_t it);
			out_item_t  exp;
			logic [2:0] f3;
			logic [31:0] imm;
			int         row;
			logic [1:0] ctr;
			exp = '0;
			f3  = it.instruction_word[14:12];
			if (it.instruction_word[6:0] == OPC_BRANCH && f3 != F3_RSV_A && f3 != F3_RSV_B) begin
				imm = {{19{it.instruction_word[31]}}, it.instruction_word[31],
					it.instruction_word[7], it.instruction_word[30:25],
					it.instruction_word[11:8], 1'b0};
				exp.is_branch     = 1'b1;
				exp.branch_target = it.branch_pc + imm;
				exp.went_taken    = (it.following_pc == exp.branch_target);
				row = int'(it.branch_pc[31:2] % TABLE_ENTRIES);
				// new or conflicting address takes the row over
				if (!row_valid[row] || row_tag[row] != it.branch_pc) begin
					row_valid[row] = 1;
					row_tag[row]   = it.branch_pc;
					row_last[row]  = 0;
					row_ctr[row]   = CTR_STRONG_NT;
				end
				exp.one_bit_right = (row_last[row] == exp.went_taken);
				row_last[row] = exp.went_taken;
				ctr = row_ctr[row];
				exp.two_bit_right = ((ctr >= CTR_WEAK_T) == exp.went_taken);
				if (exp.went_taken && ctr != CTR_STRONG_T)
					ctr = ctr + 2'd1;
				else if (!exp.went_taken && ctr != CTR_STRONG_NT)
					ctr = ctr - 2'd1;
				row_ctr[row] = ctr;
				totals.branches  = bump(totals.branches, 1);
				totals.taken     = bump(totals.taken, exp.went_taken);
				totals.not_taken = bump(totals.not_taken, !exp.went_taken);
				totals.one_bit   = bump(totals.one_bit, exp.one_bit_right);
				totals.two_bit   = bump(totals.two_bit, exp.two_bit_right);
			end
			exp.branches_seen         = totals.branches;
			exp.always_taken_hits     = totals.taken;
			exp.always_not_taken_hits = totals.not_taken;
			exp.one_bit_hits          = totals.one_bit;
			exp.two_bit_hits          = totals.two_bit;
			expected_scores.insert(expected_scores.size(), exp);
		endfunction

		function void match_field(input string field, input logic [31:0] want,
			input logic [31:0] got);
			if (got !== want) begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch in result %0d, %s: expected %h, got %h",
						results_seen, field, want, got);
			end
		endfunction

		// Compare one result item with the oldest prediction
		function void check_result(input out_item_t got);
			out_item_t exp;
			results_seen++;
			if (expected_scores.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result %0d: %h", results_seen, got);
				return;
			end
			exp = expected_scores.pop_front();
			match_field("is_branch", exp.is_branch, got.is_branch);
			match_field("branch_target", exp.branch_target, got.branch_target);
			match_field("went_taken", exp.went_taken, got.went_taken);
			match_field("one_bit_right", exp.one_bit_right, got.one_bit_right);
			match_field("two_bit_right", exp.two_bit_right, got.two_bit_right);
			match_field("branches_seen", exp.branches_seen, got.branches_seen);
			match_field("always_taken_hits", exp.always_taken_hits, got.always_taken_hits);
			match_field("always_not_taken_hits", exp.always_not_taken_hits,
				got.always_not_taken_hits);
			match_field("one_bit_hits", exp.one_bit_hits, got.one_bit_hits);
			match_field("two_bit_hits", exp.two_bit_hits, got.two_bit_hits);
		endfunction

		function int outstanding();
			return expected_scores.size();
		endfunction
	endclass

	logic      clk = 0;
	logic      arst_n;
	logic      item_valid;
	logic      item_ready;
	in_item_t  item;
	logic      result_valid;
	logic      result_ready;
	out_item_t result;

	branch_score_board scores;
	int tx_idle_pct;
	int rx_idle_pct;
	int rx_hold;
	int stuck_cycles;

	// Branch sites revisited by the random part so the predictor rows get trained
	logic [31:0] site_pc   [N_SITES];
	logic [31:0] site_word [N_SITES];
	logic [31:0] site_imm  [N_SITES];
	int          site_bias [N_SITES];

	riscv_branch_predictor_scorer uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

	always #5 clk = ~clk;

	// Item and result monitors sample at the edge where the handshake completes
	always @(posedge clk) begin
		if (arst_n && item_valid && item_ready)
			scores.score_retired(item);
		if (arst_n && result_valid && result_ready)
			scores.check_result(result);
	end

	// Watchdog: cycles with no handshake on either side
	always @(posedge clk) begin
		if ((item_valid && item_ready) || (result_valid && result_ready))
			stuck_cycles = 0;
		else
			stuck_cycles++;
		if (stuck_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog expired after %0d idle cycles", stuck_cycles);
			$display("status: fail");
			$finish;
		end
	end

	// Result side: random stalls, plus a long hold-off counted down here
	initial begin
		result_ready = 0;
		forever begin
			@(posedge clk);
			if (rx_hold > 0) begin
				result_ready <= 0;
				rx_hold--;
			end else begin
				result_ready <= ($urandom_range(99) >= rx_idle_pct);
			end
		end
	end

	function automatic logic [31:0] make_branch(input logic [2:0] f3, input logic [12:0] imm);
		logic [4:0] rs1, rs2;
		rs1 = 5'($urandom);
		rs2 = 5'($urandom);
		return {imm[12], imm[10:5], rs2, rs1, f3, imm[4:1], imm[11], OPC_BRANCH};
	endfunction

	function automatic logic [2:0] pick_branch_f3();
		case ($urandom_range(5))
			0: return F3_BEQ;
			1: return F3_BNE;
			2: return F3_BLT;
			3: return F3_BGE;
			4: return F3_BLTU;
			default: return F3_BGEU;
		endcase
	endfunction

	function automatic void new_site_word(input int s);
		logic [12:0] imm;
		imm = 13'($urandom) & 13'h1FFE;
		site_word[s] = make_branch(pick_branch_f3(), imm);
		site_imm[s]  = {{19{imm[12]}}, imm};
	endfunction

	// Sites: mostly aligned pcs, some unaligned, a third sharing a row with another site
	function automatic void build_sites();
		for (int s = 0; s < N_SITES; s++) begin
			if (s >= 32)
				site_pc[s] = site_pc[s - 32] + $urandom_range(1, 3) * TABLE_ENTRIES * 4;
			else if (s % 8 == 7)
				site_pc[s] = $urandom;
			else
				site_pc[s] = $urandom & 32'hFFFF_FFFC;
			site_bias[s] = $urandom_range(100);
			new_site_word(s);
		end
	endfunction

	// Offer one item and hold it until accepted
	task automatic offer(input logic [31:0] pc, input logic [31:0] word, input logic [31:0] nx);
		in_item_t it;
		it.branch_pc        = pc;
		it.instruction_word = word;
		it.following_pc     = nx;
		while ($urandom_range(99) < tx_idle_pct) begin
			item_valid <= 0;
			@(posedge clk);
		end
		item_valid <= 1;
		item       <= it;
		do @(posedge clk); while (!item_ready);
	endtask

	// Mostly trained branch sites, some arbitrary branch-opcode words, some noise
	task automatic offer_random();
		int          kind, s;
		logic [31:0] pc, word, nx;
		logic [12:0] imm;
		kind = $urandom_range(99);
		if (kind < 80) begin
			s = $urandom_range(N_SITES - 1);
			if ($urandom_range(99) < 2)
				new_site_word(s);
			pc   = site_pc[s];
			word = site_word[s];
			if ($urandom_range(99) < 5)
				nx = $urandom;
			else if ($urandom_range(99) < site_bias[s])
				nx = pc + site_imm[s];
			else
				nx = pc + 32'd4;
		end else if (kind < 90) begin
			imm  = 13'($urandom) & 13'h1FFE;
			pc   = $urandom;
			word = make_branch(3'($urandom), imm);
			nx   = $urandom_range(1) ? pc + {{19{imm[12]}}, imm} : $urandom;
		end else begin
			pc   = $urandom;
			word = $urandom;
			nx   = $urandom;
		end
		offer(pc, word, nx);
	endtask

	// Wait on the clock before checking, so the last accepted item is already queued
	task automatic wait_drained();
		do @(posedge clk); while (scores.outstanding() > 0);
	endtask

	task automatic random_phase(input int n_items, input int tx_pct, input int rx_pct);
		tx_idle_pct = tx_pct;
		rx_idle_pct = rx_pct;
		for (int i = 0; i < n_items; i++)
			offer_random();
	endtask

	initial begin
		scores       = new();
		arst_n       = 0;
		item_valid   = 0;
		item         = '0;
		tx_idle_pct  = 28;
		rx_idle_pct  = 68;
		rx_hold      = 0;
		stuck_cycles = 0;
		build_sites();
		repeat (6) @(posedge clk);
		arst_n <= 1;

		// Directed: noise words, reserved funct3, counter walk, row conflict, wrap
		offer(32'h0, 32'h0, 32'h0);
		offer(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		offer(32'h40, make_branch(F3_RSV_A, 13'd8), 32'h48);
		offer(32'h44, make_branch(F3_RSV_B, 13'd8), 32'h4C);
		for (int i = 0; i < 4; i++)
			offer(32'h100, make_branch(F3_BEQ, 13'd8), 32'h108);
		for (int i = 0; i < 4; i++)
			offer(32'h100, make_branch(F3_BEQ, 13'd8), 32'h104);
		offer(32'h100 + TABLE_ENTRIES * 4, make_branch(F3_BNE, 13'd8),
			32'h108 + TABLE_ENTRIES * 4);
		offer(32'h100, make_branch(F3_BEQ, 13'd8), 32'h108);
		offer(32'hFFFF_F800, make_branch(F3_BLT, 13'h0FFE), 32'h0000_07FE);
		offer(32'h10, make_branch(F3_BGE, 13'h1000), 32'hFFFF_F010);
		offer(32'hFFFF_FFFC, make_branch(F3_BLTU, 13'h0), 32'hFFFF_FFFC);
		offer(32'h8000_0002, make_branch(F3_BGEU, 13'h1FFE), 32'h0);
		offer(32'hFFFF_FFFF, make_branch(F3_BEQ, 13'd2), 32'hFFFF_FFFF);
		offer(32'h2000, 32'hFFFF_FFE3, 32'h1FFE);
		offer(32'h0, 32'h0000_0063, 32'h0);

		// Sender pauses until every result is back, then the receiver holds off
		item_valid <= 0;
		wait_drained();
		rx_hold = RX_HOLD_CYCLES;
		random_phase(560, 28, 68);
		item_valid <= 0;
		wait_drained();
		random_phase(600, 68, 28);
		item_valid <= 0;
		wait_drained();
		random_phase(540, 0, 0);
		item_valid <= 0;

		// Drain, then let the clock run on to catch any stray result
		wait_drained();
		repeat (10) @(posedge clk);
		if (scores.mismatches == 0 && scores.outstanding() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end
endmodule

>>> filelist.f
rtl/core/bps_pkg.sv
rtl/core/bps_decode.sv
rtl/core/bps_table.sv
rtl/core/bps_score.sv
rtl/core/riscv_branch_predictor_scorer.sv
bench/riscv_branch_predictor_scorer_tb.sv
